[hw/rtl/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg: shared types and constants for the trial division prime test
// Holds the value width, the derived widths of the divisor, square and
// counter registers, the sequencer state type and the remainder status.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Width of the candidate and of the echoed value.
    localparam int VALUE_BITS = 30;

    // The divisor never passes floor(sqrt(candidate)) + 1.
    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;

    // The running square of the divisor stays below 2 ** (VALUE_BITS + 1).
    localparam int SQ_BITS = VALUE_BITS + 1;

    // Bit counter of the serial remainder unit.
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    // Stream data widths, padded to whole bytes.
    localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS = ((VALUE_BITS + 1 + 7) / 8) * 8;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } tdpt_state_t;

    // Status returned by the remainder unit.
    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

[hw/rtl/tdpt_rem.sv]
// ----------------------------------------------------------------------------
// tdpt_rem: bit-serial remainder unit
// Restoring division, one candidate bit per cycle from the top bit down.
// Reports on a one-cycle done pulse whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdpt_rem (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [tdpt_pkg::VALUE_BITS-1:0]   dividend,
    input  logic [tdpt_pkg::DIV_BITS-1:0]     divisor,
    output tdpt_pkg::rem_status_t             status
);

    logic [tdpt_pkg::VALUE_BITS-1:0] shift_reg, shift_next;
    logic [tdpt_pkg::DIV_BITS-1:0]   rem_reg, rem_next;
    logic [tdpt_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [tdpt_pkg::DIV_BITS:0]     trial;
    logic [tdpt_pkg::DIV_BITS:0]     trial_diff;

    // One restoring step: bring down the next bit and subtract if it fits.
    assign trial      = {rem_reg, shift_reg[tdpt_pkg::VALUE_BITS-1]};
    assign trial_diff = trial - {1'b0, divisor};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = dividend;
            rem_next   = '0;
            cnt_next   = tdpt_pkg::CNT_BITS'(tdpt_pkg::VALUE_BITS);
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = shift_reg << 1;
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial_diff[tdpt_pkg::DIV_BITS-1:0];
            end else begin
                rem_next = trial[tdpt_pkg::DIV_BITS-1:0];
            end
            cnt_next = cnt_reg - tdpt_pkg::CNT_BITS'(1);
            if (cnt_reg == tdpt_pkg::CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the data path needs none.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

[hw/rtl/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by trial division
// Tries divisors from 2 upward until one divides the candidate or its square
// passes it; 0 and 1 are not prime. Returns the verdict with the candidate.
//
//   Channel   Direction  Item contents (lowest bit first)
//   s_        in         tdata: candidate
//   m_        out        tdata: is_prime, tested_value
//
// Each divisor is tried by the bit-serial remainder unit; an item tries at
// most floor(sqrt(candidate)) - 1 divisors.
// One item is worked on at a time. The next item is taken while the last
// result still waits in the output register.
// Reset is synchronous and active low and empties the block.
// ----------------------------------------------------------------------------
module trial_division_prime_test (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tdpt_pkg::S_DATA_BITS-1:0]   s_tdata,  // candidate
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tdpt_pkg::M_DATA_BITS-1:0]   m_tdata   // is_prime, tested_value
);

    tdpt_pkg::tdpt_state_t state_reg, state_next;

    logic [tdpt_pkg::VALUE_BITS-1:0] n_reg, n_next;
    logic [tdpt_pkg::DIV_BITS-1:0]   d_reg, d_next;
    logic [tdpt_pkg::SQ_BITS-1:0]    sq_reg, sq_next;
    logic                            verdict_reg, verdict_next;
    logic                            m_valid_reg, m_valid_next;
    logic                            m_prime_reg, m_prime_next;
    logic [tdpt_pkg::VALUE_BITS-1:0] m_value_reg, m_value_next;

    logic                  rem_start;
    tdpt_pkg::rem_status_t rem_status;
    logic                  in_take;
    logic                  out_free;
    logic                  too_small;
    logic                  sq_over;

    // Serial remainder of the candidate by the current divisor.
    tdpt_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    assign in_take   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign too_small = (n_reg < tdpt_pkg::VALUE_BITS'(2));
    assign sq_over   = (sq_reg > {1'b0, n_reg});

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                if (in_take) begin
                    state_next = tdpt_pkg::ST_CHECK;
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (too_small || sq_over) begin
                    state_next = tdpt_pkg::ST_DONE;
                end else begin
                    state_next = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        state_next = tdpt_pkg::ST_DONE;
                    end else begin
                        state_next = tdpt_pkg::ST_CHECK;
                    end
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    // Data path and output register.
    always_comb begin
        n_next       = n_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        verdict_next = verdict_reg;
        rem_start    = 1'b0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        m_value_next = m_value_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            tdpt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    n_next  = s_tdata[tdpt_pkg::VALUE_BITS-1:0];
                    d_next  = tdpt_pkg::DIV_BITS'(2);
                    sq_next = tdpt_pkg::SQ_BITS'(4);
                end
            end
            tdpt_pkg::ST_CHECK: begin
                if (too_small) begin
                    verdict_next = 1'b0;
                end else if (sq_over) begin
                    verdict_next = 1'b1;
                end else begin
                    rem_start = 1'b1;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (rem_status.done) begin
                    if (rem_status.zero) begin
                        verdict_next = 1'b0;
                    end else begin
                        // (d + 1) squared = d squared + 2d + 1
                        d_next  = d_reg + tdpt_pkg::DIV_BITS'(1);
                        sq_next = sq_reg + tdpt_pkg::SQ_BITS'({d_reg, 1'b1});
                    end
                end
            end
            tdpt_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_prime_next = verdict_reg;
                    m_value_next = n_reg;
                end
            end
            default: begin
                rem_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpt_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg       <= n_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        verdict_reg <= verdict_next;
        m_prime_reg <= m_prime_next;
        m_value_reg <= m_value_next;
    end

    // Result item: verdict in bit 0, echoed candidate above it.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = tdpt_pkg::M_DATA_BITS'({m_value_reg, m_prime_reg});

endmodule

[hw/rtl/tdpt_checker.sv]
// ----------------------------------------------------------------------------
// tdpt_checker: port-level checks for the trial division prime test
// Watches the result channel for reset behaviour, held items and verdicts
// that cannot be right and inputs taken back to back; bound to the top level.
// ----------------------------------------------------------------------------
module tdpt_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [tdpt_pkg::M_DATA_BITS-1:0]   m_tdata
);

    logic                            out_prime;
    logic [tdpt_pkg::VALUE_BITS-1:0] out_value;
    logic                            in_take;

    assign out_prime = m_tdata[0];
    assign out_value = m_tdata[tdpt_pkg::VALUE_BITS:1];
    assign in_take   = s_tvalid && s_tready;

    // No result item is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // A stalled result item holds still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

    // Zero and one are never reported prime.
    a_small: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_prime |-> out_value >= tdpt_pkg::VALUE_BITS'(2))
        else $error("zero or one reported prime");

    // An even value other than two is never reported prime.
    a_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !out_value[0] && out_value != tdpt_pkg::VALUE_BITS'(2)
        |-> !out_prime)
        else $error("even value reported prime");

    // A new item is only taken while the block is not busy, so no two
    // items are taken in consecutive cycles.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |=> !in_take)
        else $error("items taken back to back");

endmodule

bind trial_division_prime_test tdpt_checker u_tdpt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[sim/tb_trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// tb_trial_division_prime_test: self-checking bench for the prime test block
// Sends candidates on the input stream and checks every verdict, with its
// echoed value, against an in-bench trial division predictor. The run starts
// with hand-picked candidates. It then holds the result channel off for a
// long stretch and finishes with random phases that idle each side in turn.
// Most candidates are kept small or are quickly found composite, so that
// the slow prime searches stay within a sensible run time.
// ----------------------------------------------------------------------------
module tb_trial_division_prime_test;

    // One verdict as it appears on the result stream.
    typedef struct packed {
        logic                            is_prime;
        logic [tdpt_pkg::VALUE_BITS-1:0] tested_value;
    } verdict_t;

    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 200;
    localparam int RUN_LIMIT   = 8_000_000;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [tdpt_pkg::S_DATA_BITS-1:0] s_tdata  = '0;    // candidate
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [tdpt_pkg::M_DATA_BITS-1:0] m_tdata;          // is_prime, tested_value

    // Candidates still to send and verdicts still to arrive.
    logic [tdpt_pkg::S_DATA_BITS-1:0] cand_q[$];
    verdict_t                         verdict_q[$];

    // Traffic controls, changed only on the falling edge.
    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_req  = 0;

    int error_count = 0;

    trial_division_prime_test dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Trial division over the low VALUE_BITS bits; padding bits are ignored.
    function automatic verdict_t predict_verdict(
        logic [tdpt_pkg::S_DATA_BITS-1:0] word
    );
        verdict_t          v;
        longint unsigned   n;
        longint unsigned   d;
        n = 64'(word[tdpt_pkg::VALUE_BITS-1:0]);
        v.tested_value = word[tdpt_pkg::VALUE_BITS-1:0];
        v.is_prime = (n >= 2);
        for (d = 2; d * d <= n && v.is_prime; d++) begin
            if (n % d == 0)
                v.is_prime = 1'b0;
        end
        return v;
    endfunction

    // Mostly small numbers; large ones are made multiples of two or three
    // so that their search ends after a divisor or two.
    function automatic logic [tdpt_pkg::S_DATA_BITS-1:0] random_candidate();
        int                               sel;
        logic [tdpt_pkg::S_DATA_BITS-1:0] word;
        sel  = $urandom_range(99);
        word = '0;
        if (sel < 50)
            word[tdpt_pkg::VALUE_BITS-1:0] = tdpt_pkg::VALUE_BITS'($urandom_range(4095));
        else if (sel < 65)
            word[tdpt_pkg::VALUE_BITS-1:0] = tdpt_pkg::VALUE_BITS'($urandom_range(65535));
        else if (sel < 85)
            word[tdpt_pkg::VALUE_BITS-1:0] = tdpt_pkg::VALUE_BITS'(
                3 * $urandom_range(((1 << tdpt_pkg::VALUE_BITS) - 1) / 3));
        else
            word[tdpt_pkg::VALUE_BITS-1:0] = tdpt_pkg::VALUE_BITS'($urandom & ~32'd1);
        return word;
    endfunction

    // Sender: an item is taken at an edge where tvalid and tready are both
    // high; its verdict is predicted then and the next item is offered.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                verdict_q.push_back(predict_verdict(s_tdata));
            if (cand_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= cand_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, or a long hold-off when one is asked for.
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Result checker: each accepted item is matched against the oldest verdict.
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result, tdata %h", $time, m_tdata);
                error_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_tdata[0] !== want.is_prime) begin
                    $display("%0t: is_prime of %0d: expected %0b, got %0b", $time,
                             want.tested_value, want.is_prime, m_tdata[0]);
                    error_count++;
                end
                if (m_tdata[tdpt_pkg::VALUE_BITS:1] !== want.tested_value) begin
                    $display("%0t: tested_value: expected %0d, got %0d", $time,
                             want.tested_value, m_tdata[tdpt_pkg::VALUE_BITS:1]);
                    error_count++;
                end
            end
        end
    end

    // Waits until every item has been sent and every verdict has come back.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (cand_q.size() != 0 || s_tvalid || verdict_q.size() != 0);
    endtask

    task automatic push_value(longint unsigned value);
        logic [tdpt_pkg::S_DATA_BITS-1:0] word;
        word = '0;
        word[tdpt_pkg::VALUE_BITS-1:0] = value[tdpt_pkg::VALUE_BITS-1:0];
        cand_q.push_back(word);
    endtask

    // Stimulus sequence.
    initial begin
        logic [tdpt_pkg::S_DATA_BITS-1:0] padded;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Hand-picked candidates: zero and one, two and three, small squares
        // of primes, the largest primes below 2**16 and 2**20, the square
        // of a prime above a thousand and the extremes of the field.
        push_value(0);
        push_value(1);
        push_value(2);
        push_value(3);
        push_value(4);
        push_value(5);
        push_value(9);
        push_value(15);
        push_value(25);
        push_value(49);
        push_value(65521);
        push_value(65535);
        push_value(1009 * 1009);
        push_value(1048573);
        push_value(longint'(1) << (tdpt_pkg::VALUE_BITS - 1));
        push_value((longint'(1) << tdpt_pkg::VALUE_BITS) - 2);
        push_value((longint'(1) << tdpt_pkg::VALUE_BITS) - 1);
        push_value(32'h2AAA_AAAA);
        // Padding bits above the candidate set; they must not matter.
        padded = '1;
        padded[tdpt_pkg::VALUE_BITS-1:0] = tdpt_pkg::VALUE_BITS'(97);
        cand_q.push_back(padded);
        wait_drained();

        // Long hold-off on the result side while items keep coming.
        hold_req++;
        for (int i = 0; i < 8; i++)
            push_value($urandom_range(200));
        wait_drained();

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 71 : (phase == 3) ? 25 : 0;
            stall_pct = (phase == 2) ? 71 : (phase == 3) ? 25 : 0;
            for (int i = 0; i < 18; i++)
                cand_q.push_back(random_candidate());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
            error_count++;
        end
        if (error_count == 0)
            $display("trial_division_prime_test test passed");
        else
            $display("trial_division_prime_test test failed");
        $finish;
    end

    // Run limit.
    initial begin
        #(RUN_LIMIT);
        $display("%0t: timeout", $time);
        $display("trial_division_prime_test test failed");
        $finish;
    end

endmodule
